/* rtl/clustered_grid_triangle_index_gen_assert.svh */
// assertion macros used by the top-level rtl file
// the asserting module provides clk and arst_n
`ifndef CLUSTERED_GRID_TRIANGLE_INDEX_GEN_ASSERT_SVH
`define CLUSTERED_GRID_TRIANGLE_INDEX_GEN_ASSERT_SVH

// same-cycle implication, off during reset
`define CLGT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define CLGT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/clgt_pkg.sv */
`timescale 1ns / 1ps
package clgt_pkg;

	// index arithmetic wraps at this many bits before the field mask
	localparam int INDEX_BITS = 26;
	localparam int IDX_W      = 26;
	localparam int COORD_W    = 13;
	localparam int VERTS_W    = 9;
	localparam int WIN_W      = 5;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	// derived widths
	localparam int QUO_W   = COORD_W + 1;
	localparam int SPAN_W  = VERTS_W + WIN_W;
	localparam int ROW_W   = QUO_W + WIN_W;
	localparam int TILE_W  = ROW_W + 1;
	localparam int LOCAL_W = 2 * VERTS_W;
	localparam int PROD_W  = TILE_W + LOCAL_W;

	// divider pipeline shape
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES = (COORD_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

	localparam logic [IDX_W-1:0] IDX_MASK = (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
		IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_VERTS_X = 2'd0,
		REG_TILE_VERTS_Z = 2'd1,
		REG_WINDOW_TILES = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] quad_x;
		logic [COORD_W-1:0] quad_z;
	} quad_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx_first;
		logic [IDX_W-1:0] idx_second;
		logic [IDX_W-1:0] idx_third;
		logic [IDX_W-1:0] idx_fourth;
		logic [IDX_W-1:0] idx_fifth;
		logic [IDX_W-1:0] idx_sixth;
		logic             out_of_range;
	} idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
		logic               ok;
	} div_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] tx;
		logic [VERTS_W-1:0] lx;
		logic [COORD_W-1:0] tz;
		logic [VERTS_W-1:0] lz;
		logic               ok;
	} div_out_t;

endpackage

/* rtl/clgt_div_pipe.sv */
`timescale 1ns / 1ps
// two-lane pipelined restoring divider: x / div_x and z / div_z
module clgt_div_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [clgt_pkg::VERTS_W-1:0] div_x,
	input  logic [clgt_pkg::VERTS_W-1:0] div_z,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  clgt_pkg::div_in_t            in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output clgt_pkg::div_out_t           out_item
);
	import clgt_pkg::*;

	// one compare-subtract step: {quotient bit, new remainder}
	function automatic logic [VERTS_W:0] div_step(input logic [VERTS_W-1:0] rem,
			input logic b, input logic [VERTS_W-1:0] d);
		logic [VERTS_W:0] t;
		t = {rem, b};
		if (t >= {1'b0, d}) begin
			return {1'b1, VERTS_W'(t - {1'b0, d})};
		end
		return {1'b0, t[VERTS_W-1:0]};
	endfunction

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   rdy;
	logic [DIV_STAGES-1:0] pv;

	// stage registers: shifted dividend, quotient, remainder per lane
	logic [COORD_W-1:0] x_s  [DIV_STAGES];
	logic [COORD_W-1:0] z_s  [DIV_STAGES];
	logic [COORD_W-1:0] qx_s [DIV_STAGES];
	logic [COORD_W-1:0] qz_s [DIV_STAGES];
	logic [VERTS_W-1:0] rx_s [DIV_STAGES];
	logic [VERTS_W-1:0] rz_s [DIV_STAGES];
	logic               ok_s [DIV_STAGES];

	logic [COORD_W-1:0] nx  [DIV_STAGES];
	logic [COORD_W-1:0] nz  [DIV_STAGES];
	logic [COORD_W-1:0] nqx [DIV_STAGES];
	logic [COORD_W-1:0] nqz [DIV_STAGES];
	logic [VERTS_W-1:0] nrx [DIV_STAGES];
	logic [VERTS_W-1:0] nrz [DIV_STAGES];
	logic               nok [DIV_STAGES];

	// per-stage ready so bubbles are squeezed out under stall
	always_comb begin
		rdy[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign pv = {vld_s[DIV_STAGES-2:0], in_valid};

	// steps of each stage
	always_comb begin
		logic [COORD_W-1:0] cx, cz, cqx, cqz;
		logic [VERTS_W-1:0] crx, crz;
		logic [VERTS_W:0]   sx, sz;
		logic               cok;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				cx  = in_item.x;
				cz  = in_item.z;
				cqx = '0;
				cqz = '0;
				crx = '0;
				crz = '0;
				cok = in_item.ok;
			end else begin
				cx  = x_s[k-1];
				cz  = z_s[k-1];
				cqx = qx_s[k-1];
				cqz = qz_s[k-1];
				crx = rx_s[k-1];
				crz = rz_s[k-1];
				cok = ok_s[k-1];
			end
			for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
				if (k * DIV_STEPS_PER_STAGE + s < COORD_W) begin
					sx  = div_step(crx, cx[COORD_W-1], div_x);
					sz  = div_step(crz, cz[COORD_W-1], div_z);
					crx = sx[VERTS_W-1:0];
					crz = sz[VERTS_W-1:0];
					cqx = {cqx[COORD_W-2:0], sx[VERTS_W]};
					cqz = {cqz[COORD_W-2:0], sz[VERTS_W]};
					cx  = cx << 1;
					cz  = cz << 1;
				end
			end
			nx[k]  = cx;
			nz[k]  = cz;
			nqx[k] = cqx;
			nqz[k] = cqz;
			nrx[k] = crx;
			nrz[k] = crz;
			nok[k] = cok;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= pv[k];
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (rdy[k] && pv[k]) begin
				x_s[k]  <= nx[k];
				z_s[k]  <= nz[k];
				qx_s[k] <= nqx[k];
				qz_s[k] <= nqz[k];
				rx_s[k] <= nrx[k];
				rz_s[k] <= nrz[k];
				ok_s[k] <= nok[k];
			end
		end
	end

	assign in_ready      = rdy[0];
	assign out_valid     = vld_s[DIV_STAGES-1];
	assign out_item.tx   = qx_s[DIV_STAGES-1];
	assign out_item.lx   = rx_s[DIV_STAGES-1];
	assign out_item.tz   = qz_s[DIV_STAGES-1];
	assign out_item.lz   = rz_s[DIV_STAGES-1];
	assign out_item.ok   = ok_s[DIV_STAGES-1];

endmodule

/* rtl/clustered_grid_triangle_index_gen.sv */
`timescale 1ns / 1ps
// Triangle index generator for a tiled terrain window. Each quad transaction
// (quad_x, quad_z) yields one result carrying the six vertex-buffer indices
// of the quad's two triangles in the order v00, v11, v01, v00, v10, v11, or
// out_of_range with zero indices when the quad does not fit in the window.
// One quad is accepted per clock unless a stall on the result side holds input;
// each result passes 12 register stages after its quad is accepted: 7 stages of a
// pipelined divider (two quotient bits per stage, one in the last) that splits
// each corner into tile and local offset, then 5 stages of tile-row, local
// and tile-size products and the final index sums. Every stage has its own
// valid bit, so a stall on the result side fills empty stages before input
// is held. Write the configuration registers only while no transaction is in
// flight.
`include "clustered_grid_triangle_index_gen_assert.svh"
module clustered_grid_triangle_index_gen (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [clgt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [clgt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            quad_valid,
	output logic                            quad_ready,
	input  clgt_pkg::quad_t                 quad,
	output logic                            idx_valid,
	input  logic                            idx_ready,
	output clgt_pkg::idx_t                  idx
);
	import clgt_pkg::*;

	// corner codes: bit 0 is the x offset, bit 1 the z offset
	localparam logic [1:0] C00 = 2'd0;
	localparam logic [1:0] C10 = 2'd1;
	localparam logic [1:0] C01 = 2'd2;
	localparam logic [1:0] C11 = 2'd3;

	logic [VERTS_W-1:0] tile_verts_x_q;
	logic [VERTS_W-1:0] tile_verts_z_q;
	logic [WIN_W-1:0]   window_tiles_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_verts_x_q <= VERTS_W'(16);
			tile_verts_z_q <= VERTS_W'(16);
			window_tiles_q <= WIN_W'(3);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_TILE_VERTS_X: tile_verts_x_q <= cfg_data;
				REG_TILE_VERTS_Z: tile_verts_z_q <= cfg_data;
				REG_WINDOW_TILES: window_tiles_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// window check on entry
	logic [SPAN_W-1:0] span_x, span_z, x_p1, z_p1;
	div_in_t  div_in;
	div_out_t div_out;
	logic     div_valid;

	assign span_x = SPAN_W'(window_tiles_q) * SPAN_W'(tile_verts_x_q);
	assign span_z = SPAN_W'(window_tiles_q) * SPAN_W'(tile_verts_z_q);
	assign x_p1   = SPAN_W'(quad.quad_x) + SPAN_W'(1);
	assign z_p1   = SPAN_W'(quad.quad_z) + SPAN_W'(1);

	assign div_in.x  = quad.quad_x;
	assign div_in.z  = quad.quad_z;
	assign div_in.ok = (x_p1 < span_x) && (z_p1 < span_z);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	clgt_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.div_x     (tile_verts_x_q),
		.div_z     (tile_verts_z_q),
		.in_valid  (quad_valid),
		.in_ready  (quad_ready),
		.in_item   (div_in),
		.out_valid (div_valid),
		.out_ready (rdy_s1),
		.out_item  (div_out)
	);

	// stage readiness
	assign rdy_s5 = !v_s5 || idx_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= div_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// s1: tile and local offset of the base and +1 corners from the divider result
	logic               wrap_x, wrap_z;
	logic [QUO_W-1:0]   tx_s1 [2];
	logic [QUO_W-1:0]   tz_s1 [2];
	logic [VERTS_W-1:0] lx_s1 [2];
	logic [VERTS_W-1:0] lz_s1 [2];
	logic               ok_s1;

	assign wrap_x = (VERTS_W'(div_out.lx) + VERTS_W'(1) == tile_verts_x_q) &&
		(div_out.lx != {VERTS_W{1'b1}});
	assign wrap_z = (VERTS_W'(div_out.lz) + VERTS_W'(1) == tile_verts_z_q) &&
		(div_out.lz != {VERTS_W{1'b1}});

	always_ff @(posedge clk) begin
		if (rdy_s1 && div_valid) begin
			tx_s1[0] <= QUO_W'(div_out.tx);
			tx_s1[1] <= QUO_W'(div_out.tx) + QUO_W'(wrap_x);
			tz_s1[0] <= QUO_W'(div_out.tz);
			tz_s1[1] <= QUO_W'(div_out.tz) + QUO_W'(wrap_z);
			lx_s1[0] <= div_out.lx;
			lx_s1[1] <= wrap_x ? '0 : div_out.lx + VERTS_W'(1);
			lz_s1[0] <= div_out.lz;
			lz_s1[1] <= wrap_z ? '0 : div_out.lz + VERTS_W'(1);
			ok_s1    <= div_out.ok;
		end
	end

	// s2: tile row bases, local row offsets, tile size
	logic [ROW_W-1:0]   rb_s2 [2];
	logic [LOCAL_W-1:0] lm_s2 [2];
	logic [QUO_W-1:0]   tx_s2 [2];
	logic [VERTS_W-1:0] lx_s2 [2];
	logic [LOCAL_W-1:0] ts_s2;
	logic               ok_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int r = 0; r < 2; r++) begin
				rb_s2[r] <= ROW_W'(tz_s1[r]) * ROW_W'(window_tiles_q);
				lm_s2[r] <= LOCAL_W'(lz_s1[r]) * LOCAL_W'(tile_verts_x_q);
				tx_s2[r] <= tx_s1[r];
				lx_s2[r] <= lx_s1[r];
			end
			ts_s2 <= LOCAL_W'(tile_verts_x_q) * LOCAL_W'(tile_verts_z_q);
			ok_s2 <= ok_s1;
		end
	end

	// s3: tile number and local offset of each corner
	logic [TILE_W-1:0]  tile_s3 [4];
	logic [LOCAL_W-1:0] loc_s3  [4];
	logic [LOCAL_W-1:0] ts_s3;
	logic               ok_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			for (int c = 0; c < 4; c++) begin
				tile_s3[c] <= TILE_W'(rb_s2[c[1]]) + TILE_W'(tx_s2[c[0]]);
				loc_s3[c]  <= lm_s2[c[1]] + LOCAL_W'(lx_s2[c[0]]);
			end
			ts_s3 <= ts_s2;
			ok_s3 <= ok_s2;
		end
	end

	// s4: tile base address of each corner
	logic [PROD_W-1:0]  prod [4];
	logic [IDX_W-1:0]   base_s4 [4];
	logic [LOCAL_W-1:0] loc_s4  [4];
	logic               ok_s4;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			prod[c] = PROD_W'(tile_s3[c]) * PROD_W'(ts_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			for (int c = 0; c < 4; c++) begin
				base_s4[c] <= prod[c][IDX_W-1:0];
				loc_s4[c]  <= loc_s3[c];
			end
			ok_s4 <= ok_s3;
		end
	end

	// s5: final sums into the result register
	logic [IDX_W-1:0] vi [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			vi[c] = ok_s4 ? ((base_s4[c] + IDX_W'(loc_s4[c])) & IDX_MASK) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			idx.idx_first    <= vi[C00];
			idx.idx_second   <= vi[C11];
			idx.idx_third    <= vi[C01];
			idx.idx_fourth   <= vi[C00];
			idx.idx_fifth    <= vi[C10];
			idx.idx_sixth    <= vi[C11];
			idx.out_of_range <= !ok_s4;
		end
	end

	assign idx_valid = v_s5;

	`CLGT_ASSERT_IMP(a_oor_zero, idx_valid && idx.out_of_range, (idx.idx_first == '0) && (idx.idx_second == '0) && (idx.idx_third == '0) && (idx.idx_fifth == '0), "out-of-range transaction carries a nonzero index")
	`CLGT_ASSERT_IMP(a_repeat_corners, idx_valid && !idx.out_of_range, (idx.idx_first == idx.idx_fourth) && (idx.idx_second == idx.idx_sixth), "repeated corner indices differ")
	`CLGT_ASSERT_IMP(a_ready_when_drained, !idx_valid, quad_ready, "input held while result stage is empty")
	`CLGT_ASSERT_NEXT(a_s4_to_s5, v_s4 && rdy_s5, v_s5, "transaction lost between last two stages")

endmodule

/* dv/clustered_grid_triangle_index_gen_test.sv */
`timescale 1ns / 1ps
module clustered_grid_triangle_index_gen_test;
	import clgt_pkg::*;

	localparam int LATENCY = 11;
	localparam int CYCLE_LIMIT = 500000;
	// register index past the end of the list, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// index table predictor and in-order result checker
	class idx_scoreboard;
		logic [VERTS_W-1:0] verts_x;
		logic [VERTS_W-1:0] verts_z;
		logic [WIN_W-1:0]   win_tiles;
		idx_t               pending_idx[$];
		int                 errors;

		function new();
			verts_x = 9'd16;
			verts_z = 9'd16;
			win_tiles = 5'd3;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_TILE_VERTS_X: verts_x = data[VERTS_W-1:0];
				REG_TILE_VERTS_Z: verts_z = data[VERTS_W-1:0];
				REG_WINDOW_TILES: win_tiles = data[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		// buffer position of one grid corner, wrapped to the index width
		function longint unsigned corner_index(longint unsigned cx, longint unsigned cz);
			longint unsigned vx, vz, tx, tz, tile, lx, lz, mask;
			vx = verts_x;
			vz = verts_z;
			tx = cx / vx;
			tz = cz / vz;
			tile = tz * win_tiles + tx;
			lx = cx - tx * vx;
			lz = cz - tz * vz;
			mask = (64'd1 << INDEX_BITS) - 64'd1;
			return (lz * vx + lx + tile * vx * vz) & mask;
		endfunction

		function int pending();
			return pending_idx.size();
		endfunction

		// accepted quad transaction: work out its six indices
		function void note_quad(quad_t q);
			idx_t r;
			longint unsigned x, z, span_x, span_z, v00, v11;
			x = q.quad_x;
			z = q.quad_z;
			span_x = win_tiles;
			span_x = span_x * verts_x;
			span_z = win_tiles;
			span_z = span_z * verts_z;
			r = '0;
			r.out_of_range = 1'b1;
			if (verts_x != 0 && verts_z != 0 && win_tiles != 0 &&
					x + 1 < span_x && z + 1 < span_z) begin
				v00 = corner_index(x, z);
				v11 = corner_index(x + 1, z + 1);
				r.idx_first = IDX_W'(v00);
				r.idx_second = IDX_W'(v11);
				r.idx_third = IDX_W'(corner_index(x, z + 1));
				r.idx_fourth = IDX_W'(v00);
				r.idx_fifth = IDX_W'(corner_index(x + 1, z));
				r.idx_sixth = IDX_W'(v11);
				r.out_of_range = 1'b0;
			end
			pending_idx.push_back(r);
		endfunction

		function void cmp_field(string field, longint unsigned want, longint unsigned got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
			end
		endfunction

		// result transaction against the oldest prediction
		function void check_result(idx_t got);
			idx_t want;
			if (pending_idx.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = pending_idx.pop_front();
			cmp_field("idx_first", want.idx_first, got.idx_first);
			cmp_field("idx_second", want.idx_second, got.idx_second);
			cmp_field("idx_third", want.idx_third, got.idx_third);
			cmp_field("idx_fourth", want.idx_fourth, got.idx_fourth);
			cmp_field("idx_fifth", want.idx_fifth, got.idx_fifth);
			cmp_field("idx_sixth", want.idx_sixth, got.idx_sixth);
			cmp_field("out_of_range", want.out_of_range, got.out_of_range);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  quad_valid;
	logic                  quad_ready;
	quad_t                 quad;
	logic                  idx_valid;
	logic                  idx_ready;
	idx_t                  idx;

	idx_scoreboard sb;
	int gap_pct;
	int stall_pct;
	int cycle_count;

	clustered_grid_triangle_index_gen uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.quad_valid (quad_valid),
		.quad_ready (quad_ready),
		.quad       (quad),
		.idx_valid  (idx_valid),
		.idx_ready  (idx_ready),
		.idx        (idx)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("clustered_grid_triangle_index_gen_test: done, errors");
			$finish;
		end
	end

	// result side checks
	always @(posedge clk) begin
		if (arst_n && idx_valid && idx_ready)
			sb.check_result(idx);
	end

	// result side back-pressure in random bursts
	initial begin : ready_gen
		int stall_left;
		stall_left = 0;
		idx_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// no back-pressure at all once stalls are switched off
			if (stall_pct == 0)
				stall_left = 0;
			if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 17);
			if (stall_left > 0) begin
				idx_ready <= 1'b0;
				stall_left--;
			end else begin
				idx_ready <= 1'b1;
			end
		end
	end

	// one quad transaction, with an optional idle burst ahead of it
	task automatic send_quad(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] z);
		quad_t q;
		int n;
		q.quad_x = x;
		q.quad_z = z;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 17);
			quad_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		quad_valid <= 1'b1;
		quad <= q;
		do @(posedge clk); while (!quad_ready);
		sb.note_quad(q);
		@(negedge clk);
	endtask

	// drop valid and let the pipeline empty
	task automatic drain();
		quad_valid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
	endtask

	// register writes, one per cycle, optionally with a dropped write
	task automatic write_regs(input logic [CFG_DATA_W-1:0] vx, input logic [CFG_DATA_W-1:0] vz,
			input logic [CFG_DATA_W-1:0] win, input bit poke_unused);
		logic [CFG_IDX_W-1:0]  addr [4];
		logic [CFG_DATA_W-1:0] data [4];
		int n;
		addr[0] = REG_TILE_VERTS_X;
		addr[1] = REG_TILE_VERTS_Z;
		addr[2] = REG_WINDOW_TILES;
		addr[3] = REG_UNUSED;
		data[0] = vx;
		data[1] = vz;
		data[2] = win;
		data[3] = CFG_DATA_W'($urandom_range(0, 511));
		n = poke_unused ? 4 : 3;
		drain();
		for (int i = 0; i < n; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= addr[i];
			cfg_data <= data[i];
			@(posedge clk);
			sb.write_reg(addr[i], data[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// coordinate inside the window span, on its edge, or anywhere
	function automatic logic [COORD_W-1:0] pick_coord(longint unsigned span, bit want_in);
		longint unsigned hi;
		if (want_in && span >= 2) begin
			hi = (span - 2 > 8191) ? 8191 : span - 2;
			case ($urandom_range(0, 9))
				0: return '0;
				1: return COORD_W'(hi);
				default: return COORD_W'($urandom_range(0, int'(hi)));
			endcase
		end
		case ($urandom_range(0, 3))
			0: return (span >= 1 && span - 1 <= 8191) ? COORD_W'(span - 1) : COORD_W'(8191);
			1: return COORD_W'(8191);
			default: return COORD_W'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_verts();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return 9'd1;
			2: return CFG_DATA_W'($urandom_range(257, 511));
			3: return 9'd2;
			4: return 9'd256;
			default: return CFG_DATA_W'($urandom_range(2, 256));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0: return CFG_DATA_W'($urandom_range(0, 31));
			1: return 9'd31;
			2: return 9'd3;
			// upper data bits set, only the low bits land
			3: return CFG_DATA_W'({$urandom_range(1, 15), 5'd0} | (2 * $urandom_range(1, 15) + 1));
			default: return CFG_DATA_W'(2 * $urandom_range(1, 15) + 1);
		endcase
	endfunction

	// random quads against the current register setting
	task automatic random_phase(input int count);
		longint unsigned span_x, span_z;
		bit want_in;
		span_x = sb.win_tiles;
		span_x = span_x * sb.verts_x;
		span_z = sb.win_tiles;
		span_z = span_z * sb.verts_z;
		for (int i = 0; i < count; i++) begin
			want_in = ($urandom_range(0, 9) < 8);
			send_quad(pick_coord(span_x, want_in), pick_coord(span_z, want_in));
		end
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		quad_valid = 1'b0;
		quad = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: corners, tile crossings, window edges, bit patterns
		gap_pct = 20;
		stall_pct = 5;
		send_quad(13'd0, 13'd0);
		send_quad(13'd15, 13'd15);
		send_quad(13'd16, 13'd31);
		send_quad(13'd46, 13'd46);
		send_quad(13'd47, 13'd0);
		send_quad(13'd0, 13'd47);
		send_quad(13'd8191, 13'd8191);
		send_quad(13'h1555, 13'h0AAA);
		send_quad(13'h0AAA, 13'h1555);

		// smallest legal tiles and window
		write_regs(9'd2, 9'd2, 9'd3, 1'b0);
		send_quad(13'd0, 13'd0);
		send_quad(13'd4, 13'd4);
		send_quad(13'd5, 13'd0);

		// largest legal tiles and window
		write_regs(9'd256, 9'd256, 9'd31, 1'b0);
		send_quad(13'd7934, 13'd7934);
		send_quad(13'd7935, 13'd0);

		// a zero register leaves no room for any quad
		write_regs(9'd0, 9'd16, 9'd3, 1'b0);
		send_quad(13'd5, 13'd5);
		write_regs(9'd16, 9'd0, 9'd3, 1'b0);
		send_quad(13'd5, 13'd5);
		write_regs(9'd16, 9'd16, 9'd0, 1'b0);
		send_quad(13'd5, 13'd5);

		// single-vertex tiles
		write_regs(9'd1, 9'd1, 9'd5, 1'b0);
		send_quad(13'd3, 13'd3);
		send_quad(13'd4, 13'd0);

		// oversized tiles with even window, index wraps
		write_regs(9'd511, 9'd511, 9'd30, 1'b0);
		send_quad(13'd8190, 13'd8190);
		send_quad(13'd8191, 13'd8191);

		// window data with upper bits set and a write to an unused index
		write_regs(9'd16, 9'd16, 9'h1E3, 1'b1);
		send_quad(13'd46, 13'd46);
		send_quad(13'd47, 13'd47);

		// random settings with varying idle pressure
		for (int p = 0; p < 14; p++) begin
			write_regs(pick_verts(), pick_verts(), pick_window(), $urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: gap_pct = 0;
				1: gap_pct = 5;
				2: gap_pct = 20;
				default: gap_pct = 50;
			endcase
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 3;
				2: stall_pct = 10;
				default: stall_pct = 30;
			endcase
			random_phase(100);
		end

		// closing stretch at full rate
		write_regs(CFG_DATA_W'($urandom_range(2, 256)), CFG_DATA_W'($urandom_range(2, 256)),
			CFG_DATA_W'(2 * $urandom_range(1, 15) + 1), 1'b0);
		drain();
		gap_pct = 0;
		stall_pct = 0;
		random_phase(150);

		drain();
		repeat (LATENCY + 8) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("clustered_grid_triangle_index_gen_test: done, clean");
		else
			$display("clustered_grid_triangle_index_gen_test: done, errors");
		$finish;
	end

endmodule

/* clustered_grid_triangle_index_gen.f */
+incdir+rtl
rtl/clgt_pkg.sv
rtl/clgt_div_pipe.sv
rtl/clustered_grid_triangle_index_gen.sv
dv/clustered_grid_triangle_index_gen_test.sv
